/* rtl/sfuf_pkg.sv */
package sfuf_pkg;

    // Fixed field widths of the stream items and the configuration register.
    localparam int VERTEX_W = 10;
    localparam int RANK_W   = 4;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 24;

    localparam int DEFAULT_MAX_VERTICES = 1024;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

    // Input kind code that starts a new graph.
    localparam logic KIND_CLEAR = 1'b0;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_CYCLE   = 2'd0,
        STAT_ADDED   = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_CLEARED = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_LINK,
        S_BUMP,
        S_CLEAR,
        S_RESULT
    } state_t;

    // One finished result handed from the sequencer to the output register.
    typedef struct packed {
        status_t               status;
        logic [VERTEX_W-1:0]   edge_a;
        logic [VERTEX_W-1:0]   edge_b;
    } res_t;

endpackage

/* rtl/sfuf_ram.sv */
module sfuf_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; a read returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sfuf_ctrl.sv */
module sfuf_ctrl
    import sfuf_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             kind,
    input  logic [VERTEX_W-1:0]              vertex_a,
    input  logic [VERTEX_W-1:0]              vertex_b,
    input  logic [COUNT_W-1:0]               vertex_count,
    output logic                             mem_we,
    output logic [$clog2(MAX_VERTICES)-1:0]  mem_waddr,
    output logic [$clog2(MAX_VERTICES)+RANK_W-1:0] mem_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0]  mem_raddr,
    input  logic [$clog2(MAX_VERTICES)+RANK_W-1:0] mem_rdata,
    input  logic                             res_free,
    output logic                             res_load,
    output res_t                             res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int MW = AW + RANK_W;
    localparam int LW = ($clog2(MAX_VERTICES + 1) > COUNT_W) ?
                        $clog2(MAX_VERTICES + 1) : COUNT_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_VERTICES);
    localparam logic [AW-1:0] LAST  = AW'(MAX_VERTICES - 1);

    state_t              state_reg, state_next;
    logic                side_reg, side_next;
    logic [VERTEX_W-1:0] a_reg, a_next;
    logic [VERTEX_W-1:0] b_reg, b_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       root_a_reg, root_a_next;
    logic [AW-1:0]       root_b_reg, root_b_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [RANK_W-1:0]   rank_b_reg, rank_b_next;
    status_t             status_reg, status_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                fwd_reg, fwd_next;
    logic [MW-1:0]       fwd_data_reg, fwd_data_next;

    logic                rd_en;
    logic [MW-1:0]       q;
    logic [AW-1:0]       q_parent;
    logic [RANK_W-1:0]   q_rank;
    logic                in_range;
    logic [AW-1:0]       addr_a, addr_b, start_addr, side_root;

    function automatic logic [AW-1:0] to_addr(input logic [VERTEX_W-1:0] v);
        logic [VERTEX_W+AW-1:0] ext;
        ext = {{AW{1'b0}}, v};
        return ext[AW-1:0];
    endfunction

    // A read of the entry written in the same cycle takes the written word.
    assign q        = fwd_reg ? fwd_data_reg : mem_rdata;
    assign q_parent = q[AW-1:0];
    assign q_rank   = q[MW-1:AW];

    // Both endpoints must lie below the configured count, capped at the store depth.
    assign in_range = (LW'(vertex_a) < LW'(vertex_count)) && (LW'(vertex_a) < MAX_L) &&
                      (LW'(vertex_b) < LW'(vertex_count)) && (LW'(vertex_b) < MAX_L);

    assign addr_a     = to_addr(a_reg);
    assign addr_b     = to_addr(b_reg);
    assign start_addr = side_reg ? addr_b : addr_a;
    assign side_root  = side_reg ? root_b_reg : root_a_reg;

    assign fwd_next      = rd_en && mem_we && (mem_raddr == mem_waddr);
    assign fwd_data_next = mem_wdata;

    assign res.status = status_reg;
    assign res.edge_a = a_reg;
    assign res.edge_b = b_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fwd_reg   <= fwd_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge clk)
    begin
        side_reg     <= side_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        cur_reg      <= cur_next;
        root_a_reg   <= root_a_next;
        root_b_reg   <= root_b_next;
        rank_a_reg   <= rank_a_next;
        rank_b_reg   <= rank_b_next;
        status_reg   <= status_next;
        fwd_data_reg <= fwd_data_next;
    end

    // Sequencer: sweep, find, compress, link and hand over the result.
    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        item_ready  = 1'b0;
        res_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cnt_reg;
        mem_wdata   = {RANK_W'(0), cnt_reg};
        mem_raddr   = cur_reg;
        rd_en       = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // Every entry becomes its own root with rank zero.
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {RANK_W'(0), cnt_reg};
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_RESULT;
                end
            end

            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    a_next = vertex_a;
                    b_next = vertex_b;
                    if (kind == KIND_CLEAR)
                    begin
                        a_next      = '0;
                        b_next      = '0;
                        status_next = STAT_CLEARED;
                        cnt_next    = '0;
                        state_next  = S_CLEAR;
                    end
                    else if (!in_range)
                    begin
                        status_next = STAT_RANGE;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        cur_next   = to_addr(vertex_a);
                        mem_raddr  = to_addr(vertex_a);
                        rd_en      = 1'b1;
                        state_next = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                if (q_parent == cur_reg)
                begin
                    // Root reached: keep it and its rank, then rewalk the path if the start vertex is not the root.
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        rank_b_next = q_rank;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        rank_a_next = q_rank;
                    end
                    if (start_addr != cur_reg)
                    begin
                        cur_next   = start_addr;
                        mem_raddr  = start_addr;
                        rd_en      = 1'b1;
                        state_next = S_COMP;
                    end
                    else if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        cur_next   = addr_b;
                        mem_raddr  = addr_b;
                        rd_en      = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    cur_next  = q_parent;
                    mem_raddr = q_parent;
                    rd_en     = 1'b1;
                end
            end

            S_COMP:
            begin
                // Point the vertex straight at its root and step to its old parent.
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = {q_rank, side_root};
                if (q_parent != side_root)
                begin
                    cur_next  = q_parent;
                    mem_raddr = q_parent;
                    rd_en     = 1'b1;
                end
                else if (!side_reg)
                begin
                    side_next  = 1'b1;
                    cur_next   = addr_b;
                    mem_raddr  = addr_b;
                    rd_en      = 1'b1;
                    state_next = S_FIND;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                state_next = S_RESULT;
                if (root_a_reg == root_b_reg)
                begin
                    status_next = STAT_CYCLE;
                end
                else
                begin
                    status_next = STAT_ADDED;
                    mem_we      = 1'b1;
                    if (rank_a_reg > rank_b_reg)
                    begin
                        mem_waddr = root_b_reg;
                        mem_wdata = {rank_b_reg, root_a_reg};
                    end
                    else
                    begin
                        mem_waddr = root_a_reg;
                        mem_wdata = {rank_a_reg, root_b_reg};
                        if ((rank_a_reg == rank_b_reg) && (rank_b_reg != RANK_MAX))
                        begin
                            state_next = S_BUMP;
                        end
                    end
                end
            end

            S_BUMP:
            begin
                // Equal ranks: the surviving root grows by one.
                mem_we     = 1'b1;
                mem_waddr  = root_b_reg;
                mem_wdata  = {rank_b_reg + RANK_W'(1), root_b_reg};
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/spanning_forest_union_find_core.sv */
// Kruskal edge filter over a disjoint-set forest with union by rank and full
// path compression. Each s_ transaction is either a clear (tuser 0) or an edge
// (tuser 1) with its two vertex numbers in tdata; each gives exactly one m_
// transaction whose tuser is the status (0 cycle, 1 added, 2 out of range,
// 3 cleared) and whose tdata echoes the endpoints (zero for a clear). Parent
// and rank of every vertex share one word of a single one-read, one-write RAM
// with a registered read, so the steps of a find or a compression wait on
// one read each. An in-range edge runs, for each endpoint, a find and, where
// the endpoint is not itself the root, a compression; then a link, with a rank
// update after it when two equal ranks below the maximum are joined. An
// out-of-range edge goes straight to the result; a clear sweeps the whole
// store. After reset the same sweep runs with s_tready low; configuration
// writes are taken at any time. A finished result waits in the output
// register while the next transaction is accepted.
module spanning_forest_union_find_core
    import sfuf_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // vertex_a [9:0], vertex_b [19:10], zeros
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // edge_a [9:0], edge_b [19:10], zeros
    output logic [STATUS_W-1:0] m_tuser,   // status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int MW = AW + RANK_W;

    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [MW-1:0]      mem_rdata;
    logic               res_free;
    logic               res_load;
    res_t               res;

    // Vertex count register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    // Parent and rank store.
    sfuf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Find, compress and link sequencer.
    sfuf_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .kind         (s_tuser),
        .vertex_a     (s_tdata[VERTEX_W-1:0]),
        .vertex_b     (s_tdata[2*VERTEX_W-1:VERTEX_W]),
        .vertex_count (count_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .res_free     (res_free),
        .res_load     (res_load),
        .res          (res)
    );

    // Output register between the sequencer and the result stream.
    assign res_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(TDATA_W - 2*VERTEX_W){1'b0}}, out_reg.edge_b, out_reg.edge_a};

endmodule
